### rtl/lomx_pkg.sv
// shared constants and types for the ln(1-x) series unit
package lomx_pkg;

  localparam int unsigned XW        = 32;
  localparam int unsigned TC_W      = 9;
  localparam int unsigned TOL_W     = 31;
  localparam int unsigned SUM_W     = 40;
  localparam int unsigned TERMS_SAT = 511;
  localparam int unsigned PROD_W    = 64;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

### rtl/log_one_minus_x_series_unit.sv
// top level: ln(1-x) by Taylor series with a shared multiplier and serial divider
//
// Evaluates -(x + x^2/2 + x^3/3 + ...) for a signed Q1.31 x, one transaction at
// a time. A transaction is taken when start_i is high and busy_o is low; the
// result appears on sum_value_o, terms_used_o and hit_limit_o with done_o high
// for exactly one cycle, and the receiver cannot stall it. Each term after the
// first takes four passes through a single 32x32 multiplier and then a
// bit-serial divider that divides by the term index, one quotient bit per cycle,
// on a dividend of PW = max(FRAC_BITS+1, 32) + clog2(MAX_TERMS+1) bits.
module log_one_minus_x_series_unit #(
  parameter int unsigned MAX_TERMS = 256,
  parameter int unsigned FRAC_BITS = 31
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  output logic                                busy_o,
  input  logic                                operation_i,
  input  logic signed [lomx_pkg::XW-1:0]      x_value_i,
  input  logic [lomx_pkg::TC_W-1:0]           term_count_i,
  input  logic [lomx_pkg::TOL_W-1:0]          tolerance_i,
  output logic                                done_o,
  output logic signed [lomx_pkg::SUM_W-1:0]   sum_value_o,
  output logic [lomx_pkg::TC_W-1:0]           terms_used_o,
  output logic                                hit_limit_o
);

  localparam int unsigned XW    = lomx_pkg::XW;
  localparam int unsigned PRW   = lomx_pkg::PROD_W;
  localparam int unsigned SUMW  = lomx_pkg::SUM_W;
  localparam int unsigned UP    = (FRAC_BITS >= 31) ? FRAC_BITS - 31 : 0;
  localparam int unsigned DN    = (FRAC_BITS < 31) ? 31 - FRAC_BITS : 0;
  localparam int unsigned MW    = (FRAC_BITS + 1 > 32) ? FRAC_BITS + 1 : 32;
  localparam int unsigned KW    = $clog2(MAX_TERMS + 1);
  localparam int unsigned PW    = MW + KW;
  localparam int unsigned ACC_W = MW + 5;
  localparam int unsigned CW    = MW + DN;
  localparam int unsigned RW    = ACC_W + DN + 4;

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_CHECK = 4'd1;
  localparam logic [3:0] ST_MUL0  = 4'd2;
  localparam logic [3:0] ST_MUL1  = 4'd3;
  localparam logic [3:0] ST_MUL2  = 4'd4;
  localparam logic [3:0] ST_MUL3  = 4'd5;
  localparam logic [3:0] ST_DIV   = 4'd6;
  localparam logic [3:0] ST_ACC   = 4'd7;
  localparam logic [3:0] ST_FIN   = 4'd8;

  logic [3:0]             state_q, state_d;
  logic                   op_q, op_d;
  logic                   xneg_q, xneg_d;
  logic [XW-1:0]          xmag_q, xmag_d;
  logic [KW-1:0]          n_q, n_d;
  logic [lomx_pkg::TOL_W-1:0] tol_q, tol_d;
  logic [MW-1:0]          mag_q, mag_d;
  logic [ACC_W-1:0]       acc_q, acc_d;
  logic                   tneg_q, tneg_d;
  logic [KW-1:0]          count_q, count_d;
  logic [PRW-1:0]         prod_q, prod_d;
  logic                   hit_q, hit_d;
  logic                   done_q, done_d;
  logic [SUMW-1:0]        sum_q, sum_d;
  logic [lomx_pkg::TC_W-1:0] terms_q, terms_d;
  logic                   hit_out_q, hit_out_d;

  logic [XW-1:0]          x_mag_in;
  logic [MW-1:0]          mag_init;
  logic [XW-1:0]          mul_a, mul_b;
  logic [PRW-1:0]         mul_p;
  logic [XW-1:0]          mag_lo, mag_hi;
  logic                   div_start;
  logic [PW-1:0]          div_dividend;
  logic [KW-1:0]          div_divisor;
  logic [PW-1:0]          div_quot;
  lomx_pkg::div_status_t  div_st;
  logic [CW-1:0]          tol_lhs, tol_rhs;
  logic                   below_tol, at_cap, fixed_done;
  logic [ACC_W-1:0]       res_mag;
  logic                   res_neg;
  logic [RW-1:0]          res_scaled, res_sat, lim;
  logic                   tneg_next;

  assign x_mag_in = x_value_i[XW-1] ? XW'(-x_value_i) : XW'(x_value_i);
  assign mag_init = (MW'(x_mag_in) << UP) >> DN;

  assign mag_lo = XW'(mag_q[30:0]);
  assign mag_hi = XW'(mag_q[MW-1:31]);

  // shared multiplier
  always_comb begin
    mul_a = mag_lo;
    mul_b = xmag_q;
    case (state_q)
      ST_MUL1: begin
        mul_a = mag_hi;
        mul_b = xmag_q;
      end
      ST_MUL2: begin
        mul_a = mag_lo;
        mul_b = XW'(count_q);
      end
      ST_MUL3: begin
        mul_a = mag_hi;
        mul_b = XW'(count_q);
      end
      default: begin
        mul_a = mag_lo;
        mul_b = xmag_q;
      end
    endcase
  end
  assign mul_p = PRW'(mul_a) * PRW'(mul_b);

  assign div_start    = (state_q == ST_MUL3);
  assign div_dividend = (PW'(mul_p) << 31) + PW'(prod_q);
  assign div_divisor  = count_q + KW'(1);

  lomx_divider #(
    .DIVIDEND_W (PW),
    .DIVISOR_W  (KW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .quotient_o (div_quot),
    .status_o   (div_st)
  );

  assign tol_lhs    = CW'(mag_q) << DN;
  assign tol_rhs    = CW'(tol_q) << UP;
  assign below_tol  = tol_lhs < tol_rhs;
  assign at_cap     = 32'(count_q) >= 32'(MAX_TERMS);
  assign fixed_done = 32'(count_q) >= 32'(n_q);
  assign tneg_next  = tneg_q ^ xneg_q;

  // result is -acc, saturated to the output range
  assign res_neg    = !acc_q[ACC_W-1] && (acc_q != '0);
  assign res_mag    = acc_q[ACC_W-1] ? -acc_q : acc_q;
  assign res_scaled = (RW'(res_mag) << DN) >> UP;
  assign lim        = RW'(1) << (SUMW - 1);
  always_comb begin
    res_sat = res_scaled;
    if (res_neg) begin
      if (res_scaled > lim) begin
        res_sat = lim;
      end
    end else if (res_scaled > lim - RW'(1)) begin
      res_sat = lim - RW'(1);
    end
  end

  always_comb begin
    state_d   = state_q;
    op_d      = op_q;
    xneg_d    = xneg_q;
    xmag_d    = xmag_q;
    n_d       = n_q;
    tol_d     = tol_q;
    mag_d     = mag_q;
    acc_d     = acc_q;
    tneg_d    = tneg_q;
    count_d   = count_q;
    prod_d    = prod_q;
    hit_d     = hit_q;
    done_d    = 1'b0;
    sum_d     = sum_q;
    terms_d   = terms_q;
    hit_out_d = hit_out_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          op_d    = operation_i;
          xneg_d  = x_value_i[XW-1];
          xmag_d  = x_mag_in;
          tol_d   = tolerance_i;
          mag_d   = mag_init;
          tneg_d  = x_value_i[XW-1];
          acc_d   = x_value_i[XW-1] ? -ACC_W'(mag_init) : ACC_W'(mag_init);
          count_d = KW'(1);
          hit_d   = 1'b0;
          if (term_count_i == '0) begin
            n_d = KW'(1);
          end else if (32'(term_count_i) > 32'(MAX_TERMS)) begin
            n_d = KW'(MAX_TERMS);
          end else begin
            n_d = KW'(term_count_i);
          end
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (!op_q) begin
          state_d = fixed_done ? ST_FIN : ST_MUL0;
        end else if (below_tol) begin
          state_d = ST_FIN;
        end else if (at_cap) begin
          hit_d   = 1'b1;
          state_d = ST_FIN;
        end else begin
          state_d = ST_MUL0;
        end
      end
      ST_MUL0: begin
        prod_d  = mul_p;
        state_d = ST_MUL1;
      end
      ST_MUL1: begin
        mag_d   = MW'(mul_p + (prod_q >> 31));
        state_d = ST_MUL2;
      end
      ST_MUL2: begin
        prod_d  = mul_p;
        state_d = ST_MUL3;
      end
      ST_MUL3: begin
        state_d = ST_DIV;
      end
      ST_DIV: begin
        if (div_st.done) begin
          state_d = ST_ACC;
        end
      end
      ST_ACC: begin
        mag_d   = MW'(div_quot);
        tneg_d  = tneg_next;
        acc_d   = tneg_next ? acc_q - ACC_W'(div_quot[MW-1:0])
                            : acc_q + ACC_W'(div_quot[MW-1:0]);
        count_d = count_q + KW'(1);
        state_d = ST_CHECK;
      end
      ST_FIN: begin
        sum_d     = res_neg ? -SUMW'(res_sat) : SUMW'(res_sat);
        terms_d   = (32'(count_q) > lomx_pkg::TERMS_SAT) ?
                    lomx_pkg::TC_W'(lomx_pkg::TERMS_SAT) : lomx_pkg::TC_W'(count_q);
        hit_out_d = hit_q;
        done_d    = 1'b1;
        state_d   = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q      <= op_d;
    xneg_q    <= xneg_d;
    xmag_q    <= xmag_d;
    n_q       <= n_d;
    tol_q     <= tol_d;
    mag_q     <= mag_d;
    acc_q     <= acc_d;
    tneg_q    <= tneg_d;
    count_q   <= count_d;
    prod_q    <= prod_d;
    hit_q     <= hit_d;
    sum_q     <= sum_d;
    terms_q   <= terms_d;
    hit_out_q <= hit_out_d;
  end

  assign busy_o       = (state_q != ST_IDLE);
  assign done_o       = done_q;
  assign sum_value_o  = $signed(sum_q);
  assign terms_used_o = terms_q;
  assign hit_limit_o  = hit_out_q;

  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o)
    else $error("accepted transaction did not make the unit busy");

  a_done_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(state_q == ST_FIN))
    else $error("result strobe without finishing step");

  a_hit_tol_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && hit_limit_o |-> op_q)
    else $error("term cap flag raised in fixed mode");

  a_terms_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> terms_used_o != '0)
    else $error("result reports zero terms");

  a_div_to_acc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DIV && div_st.done |=> state_q == ST_ACC)
    else $error("divider completion not followed by accumulate");

endmodule

### rtl/lomx_divider.sv
// bit-serial restoring divider, one quotient bit per cycle
module lomx_divider #(
  parameter int unsigned DIVIDEND_W = 41,
  parameter int unsigned DIVISOR_W  = 9
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [DIVIDEND_W-1:0]     dividend_i,
  input  logic [DIVISOR_W-1:0]      divisor_i,
  output logic [DIVIDEND_W-1:0]     quotient_o,
  output lomx_pkg::div_status_t     status_o
);

  localparam int unsigned CNT_W = $clog2(DIVIDEND_W + 1);

  logic [DIVIDEND_W-1:0] dq_q, dq_d;
  logic [DIVISOR_W-1:0]  rem_q, rem_d;
  logic [DIVISOR_W-1:0]  dvs_q, dvs_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic                  busy_q, busy_d;
  logic                  done_q, done_d;
  logic [DIVISOR_W:0]    trial;
  logic                  fits;

  assign trial = {rem_q, dq_q[DIVIDEND_W-1]};
  assign fits  = trial >= {1'b0, dvs_q};

  always_comb begin
    dq_d   = dq_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i && !busy_q) begin
      dq_d   = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
      cnt_d  = CNT_W'(DIVIDEND_W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = fits ? DIVISOR_W'(trial - {1'b0, dvs_q}) : trial[DIVISOR_W-1:0];
      dq_d  = {dq_q[DIVIDEND_W-2:0], fits};
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dq_q  <= dq_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign quotient_o    = dq_q;
  assign status_o.busy = busy_q;
  assign status_o.done = done_q;

endmodule
